FILE: rtl/bdrc_pkg.sv
package bdrc_pkg;

	// Table size: one cell of the chain per slot
	localparam int SLOTS = 16;

	// Request kinds
	localparam logic [1:0] REQ_REGISTER = 2'd0;
	localparam logic [1:0] REQ_READ     = 2'd1;
	localparam logic [1:0] REQ_WRITE    = 2'd2;
	localparam logic [1:0] REQ_INFO     = 2'd3;

	// Result status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_NOMEM  = 3'd1;
	localparam logic [2:0] ST_NODEV  = 3'd2;
	localparam logic [2:0] ST_INVAL  = 3'd3;
	localparam logic [2:0] ST_RDONLY = 3'd4;

	// Bit of the flags that marks a read-only device
	localparam int FLAG_READ_ONLY_BIT = 0;

	// Token that walks the chain of slot cells, one cell per cycle
	typedef struct packed {
		logic        valid;
		logic [1:0]  req;
		logic [31:0] num;
		logic [7:0]  new_type;
		logic [7:0]  new_flags;
		logic [63:0] new_cap;
		logic [15:0] new_bytes;
		logic [15:0] new_endpoint;
		logic [31:0] next_num;
		logic        claimed;
		logic        found;
		logic [7:0]  f_type;
		logic [7:0]  f_flags;
		logic [63:0] f_cap;
		logic [15:0] f_bytes;
	} probe_t;

endpackage

FILE: rtl/bdrc_cell.sv
module bdrc_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  bdrc_pkg::probe_t probe_in,
	output bdrc_pkg::probe_t probe_out
);

	logic        present_q;
	logic [31:0] number_q;
	logic [7:0]  type_q;
	logic [7:0]  flags_q;
	logic [63:0] cap_q;
	logic [15:0] bytes_q;
	logic [15:0] endpoint_q;

	logic            claim;
	logic            match;
	bdrc_pkg::probe_t probe_d;
	bdrc_pkg::probe_t probe_q;

	// Take the slot if it is the first free one the request meets
	assign claim = probe_in.valid && (probe_in.req == bdrc_pkg::REQ_REGISTER) &&
		!probe_in.claimed && !present_q;

	// Answer a lookup if this is the first present slot with the number
	assign match = probe_in.valid && (probe_in.req != bdrc_pkg::REQ_REGISTER) &&
		!probe_in.found && present_q && (number_q == probe_in.num);

	// Mark the request and attach the slot contents on a hit
	always_comb begin
		probe_d = probe_in;
		if (claim) begin
			probe_d.claimed = 1'b1;
		end
		if (match) begin
			probe_d.found   = 1'b1;
			probe_d.f_type  = type_q;
			probe_d.f_flags = flags_q;
			probe_d.f_cap   = cap_q;
			probe_d.f_bytes = bytes_q;
		end
	end

	// Hand the request to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_d;
		end
	end

	// Hold presence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
		end else if (claim) begin
			present_q <= 1'b1;
		end
	end

	// Store the new device on a claim
	always_ff @(posedge clk) begin
		if (claim) begin
			number_q   <= probe_in.next_num;
			type_q     <= probe_in.new_type;
			flags_q    <= probe_in.new_flags;
			cap_q      <= probe_in.new_cap;
			bytes_q    <= probe_in.new_bytes;
			endpoint_q <= probe_in.new_endpoint;
		end
	end

	assign probe_out = probe_q;

endmodule

FILE: rtl/block_device_request_checker_top.sv
// Channel | Direction | tdata fields (low bit up)                         | tuser
// s_*     | in        | device_number, first_block, block_total_req,      | req_type
//         |           | new_type, new_flags, new_capacity,                |
//         |           | new_block_bytes, new_endpoint                     |
// m_*     | out       | assigned_number, done_count, info_type,           | status
//         |           | info_flags, info_capacity, info_block_bytes,      |
//         |           | read_req_count, write_req_count, read_block_sum,  |
//         |           | write_block_sum                                   |
//
// One request at a time: it walks the chain of SLOTS slot cells, one cell per
// cycle, is captured in a hold register at the end of the chain and resolved
// from there into the registered result; the next request can be taken once
// the previous one has been resolved.
// Reset clears all slots, sets the next device number to one, clears counters.
// A result waiting on m_tready does not stop the next request from entering;
// that request holds at the resolve step until the result is taken.
module block_device_request_checker_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// device_number, first_block, block_total_req, new_type, new_flags,
	// new_capacity, new_block_bytes, new_endpoint
	input  logic [239:0] s_tdata,
	// req_type
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// assigned_number, done_count, info_type, info_flags, info_capacity,
	// info_block_bytes, read_req_count, write_req_count, read_block_sum,
	// write_block_sum
	output logic [415:0] m_tdata,
	// status
	output logic [2:0]   m_tuser
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_PEND = 2'd2;

	logic [1:0] state_q;

	logic [63:0] first_q;
	logic [31:0] count_q;
	logic [31:0] next_num_q;
	logic [63:0] rd_cnt_q;
	logic [63:0] wr_cnt_q;
	logic [63:0] rd_sum_q;
	logic [63:0] wr_sum_q;

	bdrc_pkg::probe_t probe_in;
	bdrc_pkg::probe_t pend_q;
	bdrc_pkg::probe_t chain [bdrc_pkg::SLOTS+1];

	logic        m_tvalid_q;
	logic [2:0]  st_q;
	logic [31:0] assigned_q;
	logic [31:0] done_q;
	logic [7:0]  itype_q;
	logic [7:0]  iflags_q;
	logic [63:0] icap_q;
	logic [15:0] ibytes_q;

	logic [2:0]  st_d;
	logic [31:0] assigned_d;
	logic [31:0] done_d;
	logic [7:0]  itype_d;
	logic [7:0]  iflags_d;
	logic [63:0] icap_d;
	logic [15:0] ibytes_d;

	logic        accept;
	logic        resolve;
	logic        range_bad;
	logic [64:0] range_end;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign resolve  = (state_q == S_PEND) && (!m_tvalid_q || m_tready);

	// Launch the request into the first cell
	always_comb begin
		probe_in              = '0;
		probe_in.valid        = accept;
		probe_in.req          = s_tuser;
		probe_in.num          = s_tdata[31:0];
		probe_in.new_type     = s_tdata[135:128];
		probe_in.new_flags    = s_tdata[143:136];
		probe_in.new_cap      = s_tdata[207:144];
		probe_in.new_bytes    = s_tdata[223:208];
		probe_in.new_endpoint = s_tdata[239:224];
		probe_in.next_num     = next_num_q;
	end

	assign chain[0] = probe_in;

	for (genvar i = 0; i < bdrc_pkg::SLOTS; i++) begin : g_cell
		bdrc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.probe_in (chain[i]),
			.probe_out(chain[i+1])
		);
	end

	// Sequence one request through scan and resolve
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (chain[bdrc_pkg::SLOTS].valid) state_q <= S_PEND;
				end
				S_PEND: begin
					if (resolve) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold the range operands and the token leaving the chain
	always_ff @(posedge clk) begin
		if (accept) begin
			first_q <= s_tdata[95:32];
			count_q <= s_tdata[127:96];
		end
		if (state_q == S_SCAN && chain[bdrc_pkg::SLOTS].valid) begin
			pend_q <= chain[bdrc_pkg::SLOTS];
		end
	end

	// Range end one bit wider than the capacity so it cannot wrap
	assign range_end = {1'b0, first_q} + {33'd0, count_q};
	assign range_bad = range_end > {1'b0, pend_q.f_cap};

	// Resolve status, counters and the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_num_q <= 32'd1;
			rd_cnt_q   <= '0;
			wr_cnt_q   <= '0;
			rd_sum_q   <= '0;
			wr_sum_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (resolve) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			if (resolve) begin
				case (pend_q.req)
					bdrc_pkg::REQ_REGISTER: begin
						if (pend_q.claimed) next_num_q <= next_num_q + 32'd1;
					end
					bdrc_pkg::REQ_READ: begin
						rd_cnt_q <= rd_cnt_q + 64'd1;
						if (pend_q.found && !range_bad) begin
							rd_sum_q <= rd_sum_q + {32'd0, count_q};
						end
					end
					bdrc_pkg::REQ_WRITE: begin
						wr_cnt_q <= wr_cnt_q + 64'd1;
						if (pend_q.found && !pend_q.f_flags[bdrc_pkg::FLAG_READ_ONLY_BIT] &&
							!range_bad) begin
							wr_sum_q <= wr_sum_q + {32'd0, count_q};
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Build the result payload
	always_comb begin
		st_d       = bdrc_pkg::ST_OK;
		assigned_d = '0;
		done_d     = '0;
		itype_d    = '0;
		iflags_d   = '0;
		icap_d     = '0;
		ibytes_d   = '0;
		case (pend_q.req)
			bdrc_pkg::REQ_REGISTER: begin
				if (pend_q.claimed) assigned_d = next_num_q;
				else st_d = bdrc_pkg::ST_NOMEM;
			end
			bdrc_pkg::REQ_READ: begin
				if (!pend_q.found) st_d = bdrc_pkg::ST_NODEV;
				else if (range_bad) st_d = bdrc_pkg::ST_INVAL;
				else done_d = count_q;
			end
			bdrc_pkg::REQ_WRITE: begin
				if (!pend_q.found) st_d = bdrc_pkg::ST_NODEV;
				else if (pend_q.f_flags[bdrc_pkg::FLAG_READ_ONLY_BIT])
					st_d = bdrc_pkg::ST_RDONLY;
				else if (range_bad) st_d = bdrc_pkg::ST_INVAL;
				else done_d = count_q;
			end
			default: begin
				if (!pend_q.found) begin
					st_d = bdrc_pkg::ST_NODEV;
				end else begin
					itype_d  = pend_q.f_type;
					iflags_d = pend_q.f_flags;
					icap_d   = pend_q.f_cap;
					ibytes_d = pend_q.f_bytes;
				end
			end
		endcase
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (resolve) begin
			st_q       <= st_d;
			assigned_q <= assigned_d;
			done_q     <= done_d;
			itype_q    <= itype_d;
			iflags_q   <= iflags_d;
			icap_q     <= icap_d;
			ibytes_q   <= ibytes_d;
		end
	end

	// Counters only move when the waiting result is taken, so show them live
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = st_q;
	assign m_tdata  = {wr_sum_q, rd_sum_q, wr_cnt_q, rd_cnt_q, ibytes_q, icap_q,
		iflags_q, itype_q, done_q, assigned_q};

endmodule

FILE: rtl/bdrc_checker.sv
module bdrc_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic [239:0] s_tdata,
	input logic [1:0]   s_tuser,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [415:0] m_tdata,
	input logic [2:0]   m_tuser
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Take one request at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while another is in flight");

	// Report only defined status codes
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == bdrc_pkg::ST_OK) || (m_tuser == bdrc_pkg::ST_NOMEM) ||
			(m_tuser == bdrc_pkg::ST_NODEV) || (m_tuser == bdrc_pkg::ST_INVAL) ||
			(m_tuser == bdrc_pkg::ST_RDONLY))
		else $error("undefined status code");

	// Clear number and block count on a failed request
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != bdrc_pkg::ST_OK) |-> (m_tdata[63:0] == 64'd0))
		else $error("failed request carries a number or block count");

endmodule

bind block_device_request_checker_top bdrc_checker u_bdrc_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tuser (m_tuser)
);

FILE: verif/block_device_request_checker_top_test.sv
module block_device_request_checker_top_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	// Request layout: the low 240 bits are exactly s_tdata, kind rides on s_tuser
	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] nep;
		logic [15:0] nbytes;
		logic [63:0] ncap;
		logic [7:0]  nflags;
		logic [7:0]  ntype;
		logic [31:0] count;
		logic [63:0] first;
		logic [31:0] num;
	} dev_req_t;

	// Response layout: {m_tuser, m_tdata}
	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] wr_sum;
		logic [63:0] rd_sum;
		logic [63:0] wr_cnt;
		logic [63:0] rd_cnt;
		logic [15:0] ibytes;
		logic [63:0] icap;
		logic [7:0]  iflags;
		logic [7:0]  itype;
		logic [31:0] done;
		logic [31:0] assigned;
	} dev_result_t;

	logic         clk;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [239:0] s_tdata = '0;
	logic [1:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [415:0] m_tdata;
	logic [2:0]   m_tuser;

	// Shadow copy of the device table and counters
	logic        dev_present [bdrc_pkg::SLOTS] = '{default: 1'b0};
	logic [31:0] dev_num     [bdrc_pkg::SLOTS] = '{default: '0};
	logic [7:0]  dev_type    [bdrc_pkg::SLOTS] = '{default: '0};
	logic [7:0]  dev_flags   [bdrc_pkg::SLOTS] = '{default: '0};
	logic [63:0] dev_cap     [bdrc_pkg::SLOTS] = '{default: '0};
	logic [15:0] dev_bytes   [bdrc_pkg::SLOTS] = '{default: '0};
	logic [15:0] dev_ep      [bdrc_pkg::SLOTS] = '{default: '0};
	logic [31:0] next_dev_num = 32'd1;
	logic [63:0] reads_seen = '0;
	logic [63:0] writes_seen = '0;
	logic [63:0] rd_block_total = '0;
	logic [63:0] wr_block_total = '0;

	dev_result_t pending_results[$];
	dev_result_t got_res;
	dev_result_t want_res;

	int error_count = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_left = 0;

	block_device_request_checker_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	initial begin
		forever @(posedge clk) begin
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
					pending_results.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Drive m_tready: random stalls, or a long hold-off when asked
	initial begin
		forever @(posedge clk) begin
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left = hold_left - 1;
			end else begin
				m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h (cycle %0d)", what, got, want, cycle_count);
		error_count++;
	endtask

	// Compute the response of one request and update the shadow table
	function automatic dev_result_t predict_result(input dev_req_t r);
		dev_result_t res;
		int hit;
		int slot;
		logic [64:0] span;
		res = '0;
		res.status = bdrc_pkg::ST_OK;
		hit = -1;
		slot = -1;
		span = {1'b0, r.first} + {33'b0, r.count};
		for (int i = 0; i < bdrc_pkg::SLOTS; i++) begin
			if (hit < 0 && dev_present[i] && dev_num[i] == r.num)
				hit = i;
			if (slot < 0 && !dev_present[i])
				slot = i;
		end
		case (r.kind)
			bdrc_pkg::REQ_REGISTER: begin
				if (slot < 0) begin
					res.status = bdrc_pkg::ST_NOMEM;
				end else begin
					dev_present[slot] = 1'b1;
					dev_num[slot] = next_dev_num;
					dev_type[slot] = r.ntype;
					dev_flags[slot] = r.nflags;
					dev_cap[slot] = r.ncap;
					dev_bytes[slot] = r.nbytes;
					dev_ep[slot] = r.nep;
					res.assigned = next_dev_num;
					next_dev_num = next_dev_num + 32'd1;
				end
			end
			bdrc_pkg::REQ_READ: begin
				reads_seen = reads_seen + 64'd1;
				if (hit < 0) begin
					res.status = bdrc_pkg::ST_NODEV;
				end else if (span > {1'b0, dev_cap[hit]}) begin
					res.status = bdrc_pkg::ST_INVAL;
				end else begin
					res.done = r.count;
					rd_block_total = rd_block_total + {32'b0, r.count};
				end
			end
			bdrc_pkg::REQ_WRITE: begin
				writes_seen = writes_seen + 64'd1;
				if (hit < 0) begin
					res.status = bdrc_pkg::ST_NODEV;
				end else if (dev_flags[hit][bdrc_pkg::FLAG_READ_ONLY_BIT]) begin
					res.status = bdrc_pkg::ST_RDONLY;
				end else if (span > {1'b0, dev_cap[hit]}) begin
					res.status = bdrc_pkg::ST_INVAL;
				end else begin
					res.done = r.count;
					wr_block_total = wr_block_total + {32'b0, r.count};
				end
			end
			default: begin
				if (hit < 0) begin
					res.status = bdrc_pkg::ST_NODEV;
				end else begin
					res.itype = dev_type[hit];
					res.iflags = dev_flags[hit];
					res.icap = dev_cap[hit];
					res.ibytes = dev_bytes[hit];
				end
			end
		endcase
		res.rd_cnt = reads_seen;
		res.wr_cnt = writes_seen;
		res.rd_sum = rd_block_total;
		res.wr_sum = wr_block_total;
		return res;
	endfunction

	// Check each accepted response against the oldest prediction
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_res = {m_tuser, m_tdata};
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected response, status", 64'(m_tuser), '0);
			end else begin
				want_res = pending_results.pop_front();
				if (got_res.status !== want_res.status)
					report_mismatch("status", 64'(got_res.status), 64'(want_res.status));
				if (got_res.assigned !== want_res.assigned)
					report_mismatch("assigned_number", 64'(got_res.assigned),
						64'(want_res.assigned));
				if (got_res.done !== want_res.done)
					report_mismatch("done_count", 64'(got_res.done), 64'(want_res.done));
				if (got_res.itype !== want_res.itype)
					report_mismatch("info_type", 64'(got_res.itype), 64'(want_res.itype));
				if (got_res.iflags !== want_res.iflags)
					report_mismatch("info_flags", 64'(got_res.iflags), 64'(want_res.iflags));
				if (got_res.icap !== want_res.icap)
					report_mismatch("info_capacity", got_res.icap, want_res.icap);
				if (got_res.ibytes !== want_res.ibytes)
					report_mismatch("info_block_bytes", 64'(got_res.ibytes),
						64'(want_res.ibytes));
				if (got_res.rd_cnt !== want_res.rd_cnt)
					report_mismatch("read_req_count", got_res.rd_cnt, want_res.rd_cnt);
				if (got_res.wr_cnt !== want_res.wr_cnt)
					report_mismatch("write_req_count", got_res.wr_cnt, want_res.wr_cnt);
				if (got_res.rd_sum !== want_res.rd_sum)
					report_mismatch("read_block_sum", got_res.rd_sum, want_res.rd_sum);
				if (got_res.wr_sum !== want_res.wr_sum)
					report_mismatch("write_block_sum", got_res.wr_sum, want_res.wr_sum);
			end
		end
	end

	// Offer one request; called at a rising edge, returns at the accepting edge
	task automatic send_req(input dev_req_t r);
		logic took;
		if ($urandom_range(99, 0) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= r[239:0];
		s_tuser <= r.kind;
		do begin
			@(negedge clk);
			took = s_tvalid && s_tready;
			@(posedge clk);
		end while (!took);
		pending_results.push_back(predict_result(r));
	endtask

	function automatic dev_req_t noise_req();
		dev_req_t r;
		r.kind = 2'($urandom_range(3, 0));
		r.num = $urandom;
		r.first = {$urandom, $urandom};
		r.count = $urandom;
		r.ntype = 8'($urandom);
		r.nflags = 8'($urandom);
		r.ncap = {$urandom, $urandom};
		r.nbytes = 16'($urandom);
		r.nep = 16'($urandom);
		return r;
	endfunction

	// Register request; the lookup and range fields carry noise
	task automatic send_register(input logic [7:0] ntype, input logic [7:0] nflags,
		input logic [63:0] ncap, input logic [15:0] nbytes, input logic [15:0] nep);
		dev_req_t r;
		r = noise_req();
		r.kind = bdrc_pkg::REQ_REGISTER;
		r.ntype = ntype;
		r.nflags = nflags;
		r.ncap = ncap;
		r.nbytes = nbytes;
		r.nep = nep;
		send_req(r);
	endtask

	// Read, write or info request; the registration fields carry noise
	task automatic send_access(input logic [1:0] kind, input logic [31:0] num,
		input logic [63:0] first, input logic [31:0] count);
		dev_req_t r;
		r = noise_req();
		r.kind = kind;
		r.num = num;
		r.first = first;
		r.count = count;
		send_req(r);
	endtask

	// Build a random request, mostly aimed at registered devices
	function automatic dev_req_t make_random_req();
		dev_req_t r;
		int pick;
		int hit;
		int off;
		logic [63:0] cap;
		r = noise_req();
		pick = $urandom_range(99, 0);
		if (pick < 15)
			r.kind = bdrc_pkg::REQ_REGISTER;
		else if (pick < 45)
			r.kind = bdrc_pkg::REQ_READ;
		else if (pick < 80)
			r.kind = bdrc_pkg::REQ_WRITE;
		else
			r.kind = bdrc_pkg::REQ_INFO;
		// pick the device
		pick = $urandom_range(99, 0);
		if (pick < 70 && next_dev_num > 32'd1)
			r.num = $urandom_range(int'(next_dev_num) - 1, 1);
		else if (pick < 80)
			r.num = '0;
		else if (pick < 90)
			r.num = next_dev_num;
		// capacity of a new device
		case ($urandom_range(3, 0))
			0: r.ncap = '0;
			1: r.ncap = '1;
			2: r.ncap = 64'($urandom_range(5000, 1));
			default: ;
		endcase
		// aim the block range at the edges of the addressed device
		hit = -1;
		for (int i = 0; i < bdrc_pkg::SLOTS; i++)
			if (hit < 0 && dev_present[i] && dev_num[i] == r.num)
				hit = i;
		if (hit >= 0 && (r.kind == bdrc_pkg::REQ_READ || r.kind == bdrc_pkg::REQ_WRITE)) begin
			cap = dev_cap[hit];
			case ($urandom_range(2, 0))
				0: begin
					off = $urandom_range(40, 0);
					r.first = (cap >= 64'(off)) ? cap - 64'(off) : '0;
					r.count = $urandom_range(off + 3, 0);
				end
				1: begin
					r.first = '0;
					r.count = r.count >> $urandom_range(31, 0);
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	// Lookups on an empty table
	task automatic test_empty_table();
		send_access(bdrc_pkg::REQ_INFO, 32'd1, '0, '0);
		send_access(bdrc_pkg::REQ_READ, 32'd0, '0, '0);
		send_access(bdrc_pkg::REQ_WRITE, 32'd5, 64'd10, 32'd1);
	endtask

	// Registrations with extreme field values, then read them back
	task automatic test_register_extremes();
		send_register(8'h00, 8'h00, 64'd0, 16'h0000, 16'h0000);
		send_register(8'hFF, 8'hFF, '1, 16'hFFFF, 16'hFFFF);
		send_register(8'h5A, 8'hFE, 64'd1000, 16'd512, 16'd7);
		send_access(bdrc_pkg::REQ_INFO, 32'd1, '0, '0);
		send_access(bdrc_pkg::REQ_INFO, 32'd2, '0, '0);
		send_access(bdrc_pkg::REQ_INFO, 32'd3, '0, '0);
	endtask

	// Range limits, the wide sum, and check order on writes
	task automatic test_range_edges();
		send_access(bdrc_pkg::REQ_READ, 32'd3, 64'd1000, 32'd0);
		send_access(bdrc_pkg::REQ_READ, 32'd3, 64'd1000, 32'd1);
		send_access(bdrc_pkg::REQ_READ, 32'd3, 64'd0, 32'd1000);
		send_access(bdrc_pkg::REQ_READ, 32'd3, 64'd1001, 32'd0);
		send_access(bdrc_pkg::REQ_READ, 32'd1, 64'd0, 32'd0);
		send_access(bdrc_pkg::REQ_READ, 32'd2, '1, '1);
		send_access(bdrc_pkg::REQ_READ, 32'd2, '1, 32'd0);
		send_access(bdrc_pkg::REQ_READ, 32'd2, 64'd0, '1);
		// read-only wins over a bad range
		send_access(bdrc_pkg::REQ_WRITE, 32'd2, '1, '1);
		send_access(bdrc_pkg::REQ_WRITE, 32'd99, 64'd0, 32'd1);
		send_access(bdrc_pkg::REQ_WRITE, 32'd3, 64'd999, 32'd1);
		send_access(bdrc_pkg::REQ_WRITE, 32'd3, '1, '1);
		send_access(bdrc_pkg::REQ_WRITE, 32'd1, 64'd0, 32'd0);
	endtask

	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (n) send_req(make_random_req());
	endtask

	// Fill every slot, then register into a full table
	task automatic test_table_full();
		send_idle_pct = 10;
		recv_idle_pct = 10;
		while (next_dev_num <= 32'(bdrc_pkg::SLOTS))
			send_register(8'($urandom), 8'($urandom), 64'($urandom_range(3000, 0)),
				16'($urandom), 16'($urandom));
		repeat (3)
			send_register(8'($urandom), 8'($urandom), {$urandom, $urandom},
				16'($urandom), 16'($urandom));
		send_access(bdrc_pkg::REQ_INFO, 32'(bdrc_pkg::SLOTS), '0, '0);
		send_access(bdrc_pkg::REQ_INFO, 32'(bdrc_pkg::SLOTS) + 32'd1, '0, '0);
	endtask

	// Hold off the response side so the block fills and stalls its input
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 300;
		repeat (12) send_req(make_random_req());
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_register_extremes();
		test_range_edges();
		test_random_traffic(18, 76, 115);
		test_random_traffic(76, 18, 115);
		test_random_traffic(0, 0, 115);
		test_table_full();
		test_backpressure();

		// drain outstanding responses
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
